// ===== rtl/core/mmrh_pkg.sv =====
`timescale 1ns / 1ps

package mmrh_pkg;

    localparam int NUM_ZONES   = 20;
    localparam int MAX_SAMPLES = 1024;

    localparam int DATA_W  = 32;
    localparam int WIDE_W  = DATA_W + 2;
    localparam int ADDR_W  = $clog2(MAX_SAMPLES);
    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int HIT_W   = 11;
    localparam int OIDX_W  = 5;
    localparam int ZONE_W  = $clog2(NUM_ZONES + 1);
    localparam int IDX_W   = (ZONE_W > OIDX_W) ? ZONE_W : OIDX_W;

    // floor(x / NUM_ZONES) = (x * ZONE_RECIP) >> RECIP_SHIFT for any 32-bit x
    localparam int RECIP_SHIFT = DATA_W + ZONE_W;
    localparam int RECIP_W     = DATA_W + 2;
    localparam int PROD_W      = RECIP_SHIFT + DATA_W;
    localparam logic [RECIP_W-1:0] ZONE_RECIP =
        RECIP_W'((64'd1 << RECIP_SHIFT) / NUM_ZONES + 1);

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic bin_first;
        logic scan_rd;
        logic emit;
        logic next_bin;
        logic clear_set;
    } mmrh_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic out_free;
        logic final_bin;
    } mmrh_status_t;

endpackage

// ===== rtl/core/mmrh_ram.sv =====
`timescale 1ns / 1ps

module mmrh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/mmrh_ctrl.sv =====
`timescale 1ns / 1ps

module mmrh_ctrl
    import mmrh_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    input  logic         s_last,
    output logic         s_ready,
    input  mmrh_status_t status,
    output mmrh_cmd_t    cmd
);

    localparam logic [2:0] ST_LOAD   = 3'd0;
    localparam logic [2:0] ST_DIVSET = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_BINSET = 3'd3;
    localparam logic [2:0] ST_SCAN   = 3'd4;
    localparam logic [2:0] ST_DRAIN  = 3'd5;
    localparam logic [2:0] ST_EMIT   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_LOAD: begin
                cmd.load = s_valid;
                if (s_valid && s_last) begin
                    state_next = ST_DIVSET;
                end
            end
            ST_DIVSET: begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                // one reciprocal multiply gives the bin width
                cmd.div_step = 1'b1;
                state_next   = ST_BINSET;
            end
            ST_BINSET: begin
                cmd.bin_first = 1'b1;
                state_next    = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (status.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last read word is counted in this cycle
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.final_bin) begin
                        cmd.clear_set = 1'b1;
                        state_next    = ST_LOAD;
                    end else begin
                        cmd.next_bin = 1'b1;
                        state_next   = ST_SCAN;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_LOAD);

endmodule

// ===== rtl/core/mmrh_dp.sv =====
`timescale 1ns / 1ps

module mmrh_dp
    import mmrh_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mmrh_cmd_t                cmd,
    output mmrh_status_t             status,
    input  logic signed [DATA_W-1:0] s_sample,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [OIDX_W-1:0]        m_bin_index,
    output logic signed [DATA_W-1:0] m_bin_low,
    output logic [HIT_W-1:0]         m_bin_count,
    output logic                     m_dropped,
    output logic                     m_final_bin
);

    // set tracking
    logic [CNT_W-1:0]         count_reg;
    logic signed [DATA_W-1:0] min_reg;
    logic signed [DATA_W-1:0] max_reg;
    logic                     ovf_reg;

    // divider
    logic [DATA_W-1:0]        quo_reg;
    logic [PROD_W-1:0]        prod;
    logic [DATA_W:0]          span;

    // bin walk
    logic signed [WIDE_W-1:0] low_reg;
    logic signed [WIDE_W-1:0] high_reg;
    logic signed [WIDE_W-1:0] width_wide;
    logic [IDX_W-1:0]         idx_reg;
    logic [ADDR_W-1:0]        rd_addr_reg;
    logic                     rd_vld_reg;
    logic [HIT_W-1:0]         hit_reg;
    logic [DATA_W-1:0]        rd_data;
    logic signed [WIDE_W-1:0] rd_wide;
    logic                     in_bin;

    // result word
    logic                     out_valid_reg;
    logic [OIDX_W-1:0]        out_idx_reg;
    logic signed [DATA_W-1:0] out_low_reg;
    logic [HIT_W-1:0]         out_hit_reg;
    logic                     out_drop_reg;
    logic                     out_final_reg;

    logic                     has_room;
    logic                     wr_en;

    assign has_room = (count_reg < CNT_W'(MAX_SAMPLES));
    assign wr_en    = cmd.load && has_room;

    mmrh_ram #(
        .WIDTH(DATA_W),
        .DEPTH(MAX_SAMPLES)
    ) u_store (
        .clk  (aclk),
        .we   (wr_en),
        .waddr(count_reg[ADDR_W-1:0]),
        .wdata(s_sample),
        .re   (cmd.scan_rd),
        .raddr(rd_addr_reg),
        .rdata(rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear_set) begin
            count_reg <= '0;
            min_reg   <= {1'b0, {(DATA_W-1){1'b1}}};
            max_reg   <= {1'b1, {(DATA_W-1){1'b0}}};
            ovf_reg   <= 1'b0;
        end else if (cmd.load) begin
            if (has_room) begin
                count_reg <= count_reg + CNT_W'(1);
                if (s_sample < min_reg) begin
                    min_reg <= s_sample;
                end
                if (s_sample > max_reg) begin
                    max_reg <= s_sample;
                end
            end else begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // divide (max - min) by the zone count: scale by the reciprocal, keep the high word
    assign span = {max_reg[DATA_W-1], max_reg} - {min_reg[DATA_W-1], min_reg};
    assign prod = PROD_W'(quo_reg) * PROD_W'(ZONE_RECIP);

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            quo_reg <= span[DATA_W-1:0];
        end else if (cmd.div_step) begin
            quo_reg <= prod[PROD_W-1 -: DATA_W];
        end
    end

    assign width_wide = $signed({2'b00, quo_reg});
    assign rd_wide    = $signed({{2{rd_data[DATA_W-1]}}, rd_data});
    assign in_bin     = (rd_wide >= low_reg) && (rd_wide <= high_reg);

    always_ff @(posedge aclk) begin
        if (cmd.bin_first) begin
            low_reg  <= WIDE_W'(min_reg);
            high_reg <= WIDE_W'(min_reg) + width_wide;
            idx_reg  <= '0;
        end else if (cmd.next_bin) begin
            low_reg  <= low_reg + width_wide;
            high_reg <= high_reg + width_wide;
            idx_reg  <= idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.bin_first || cmd.next_bin) begin
            rd_addr_reg <= '0;
            hit_reg     <= '0;
        end else begin
            if (cmd.scan_rd) begin
                rd_addr_reg <= rd_addr_reg + ADDR_W'(1);
            end
            // saturate the bin count
            if (rd_vld_reg && in_bin && (hit_reg != {HIT_W{1'b1}})) begin
                hit_reg <= hit_reg + HIT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.scan_rd;
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_idx_reg   <= idx_reg[OIDX_W-1:0];
            out_low_reg   <= low_reg[DATA_W-1:0];
            out_hit_reg   <= hit_reg;
            out_drop_reg  <= ovf_reg;
            out_final_reg <= status.final_bin;
        end
    end

    assign status.scan_last = ((CNT_W'(rd_addr_reg) + CNT_W'(1)) == count_reg);
    assign status.out_free  = !out_valid_reg || m_ready;
    assign status.final_bin = (idx_reg == IDX_W'(NUM_ZONES));

    assign m_valid     = out_valid_reg;
    assign m_bin_index = out_idx_reg;
    assign m_bin_low   = out_low_reg;
    assign m_bin_count = out_hit_reg;
    assign m_dropped   = out_drop_reg;
    assign m_final_bin = out_final_reg;

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> status.out_free)
        else $error("bin emitted over an untaken word");

    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_valid)
        else $error("emitted bin not presented");

    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) |-> (min_reg <= max_reg))
        else $error("running minimum above maximum");

    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_SAMPLES))
        else $error("store fill beyond capacity");

endmodule

// ===== rtl/core/min_max_range_histogram.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Handshake          Word
// s_       in   s_valid / s_ready  s_sample (32, signed), s_last
// m_       out  m_valid / m_ready  m_bin_index, m_bin_low, m_bin_count, m_dropped, m_final_bin
//
// Loading takes one sample per cycle; the store is a single-port-write RAM.
// After the word with s_last, s_ready stays low while the block takes the span,
// scales it by the reciprocal of the zone count and opens the first bin, then
// walks the store through its read port once for each of the NUM_ZONES + 1 bins;
// each bin word may also wait on m_ready.
// The final bin word may still wait on m_ready while the next set loads.
// Reset (aresetn low, synchronous) empties the set; the store itself is not cleared.

module min_max_range_histogram
    import mmrh_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_sample,
    input  logic                     s_last,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [OIDX_W-1:0]        m_bin_index,
    output logic signed [DATA_W-1:0] m_bin_low,
    output logic [HIT_W-1:0]         m_bin_count,
    output logic                     m_dropped,
    output logic                     m_final_bin
);

    mmrh_cmd_t    cmd;
    mmrh_status_t status;

    mmrh_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_last (s_last),
        .s_ready(s_ready),
        .status (status),
        .cmd    (cmd)
    );

    mmrh_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .s_sample   (s_sample),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_bin_index(m_bin_index),
        .m_bin_low  (m_bin_low),
        .m_bin_count(m_bin_count),
        .m_dropped  (m_dropped),
        .m_final_bin(m_final_bin)
    );

endmodule

// ===== dv/tb_min_max_range_histogram.sv =====
`timescale 1ns / 1ps

module tb_min_max_range_histogram;
    import mmrh_pkg::*;

    typedef struct {
        logic signed [DATA_W-1:0] sample;
        logic                     last;
        bit                       after_drain;
    } sample_word_t;

    typedef struct {
        logic [OIDX_W-1:0]        index;
        logic signed [DATA_W-1:0] low;
        logic [HIT_W-1:0]         count;
        logic                     dropped;
        logic                     final_bin;
    } bin_word_t;

    localparam int HIT_SAT = (1 << HIT_W) - 1;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic signed [DATA_W-1:0] s_sample = '0;
    logic                     s_last = 1'b0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [OIDX_W-1:0]        m_bin_index;
    logic signed [DATA_W-1:0] m_bin_low;
    logic [HIT_W-1:0]         m_bin_count;
    logic                     m_dropped;
    logic                     m_final_bin;

    min_max_range_histogram dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_bin_index (m_bin_index),
        .m_bin_low   (m_bin_low),
        .m_bin_count (m_bin_count),
        .m_dropped   (m_dropped),
        .m_final_bin (m_final_bin)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    sample_word_t pending[$];
    bin_word_t    bins_due[$];

    // histogram state mirrored for the set being loaded
    int          set_vals[$];
    int          set_min = 32'sh7FFFFFFF;
    int          set_max = 32'sh80000000;
    bit          set_overflow = 1'b0;

    int          errors = 0;
    int          sets_closed = 0;
    int          samples_taken = 0;
    int          bins_checked = 0;
    int          random_items = 0;
    int          sets_queued = 0;

    // Store the sample (or drop it when full); on last, build every bin word.
    task automatic absorb_sample(sample_word_t w);
        longint    lo;
        longint    hi;
        longint    step;
        longint    edge_lo;
        longint    edge_hi;
        int        hits;
        bin_word_t b;
        if (set_vals.size() < MAX_SAMPLES) begin
            set_vals.push_back(int'(w.sample));
            if (int'(w.sample) < set_min) set_min = int'(w.sample);
            if (int'(w.sample) > set_max) set_max = int'(w.sample);
        end else begin
            set_overflow = 1'b1;
        end
        samples_taken++;
        if (w.last) begin
            lo = set_min;
            hi = set_max;
            step = (hi - lo) / NUM_ZONES;
            for (int i = 0; i <= NUM_ZONES; i++) begin
                edge_lo = lo + step * i;
                edge_hi = edge_lo + step;
                hits = 0;
                foreach (set_vals[j]) begin
                    if (longint'(set_vals[j]) >= edge_lo && longint'(set_vals[j]) <= edge_hi
                            && hits < HIT_SAT)
                        hits++;
                end
                b.index = i[OIDX_W-1:0];
                b.low = edge_lo[DATA_W-1:0];
                b.count = hits[HIT_W-1:0];
                b.dropped = set_overflow;
                b.final_bin = (i == NUM_ZONES);
                bins_due.push_back(b);
            end
            sets_closed++;
            set_vals.delete();
            set_min = 32'sh7FFFFFFF;
            set_max = 32'sh80000000;
            set_overflow = 1'b0;
        end
    endtask

    task automatic add_sample(logic [31:0] value, logic last, bit drain);
        pending.push_back('{value, last, drain});
    endtask

    function automatic logic [31:0] draw_value(int mode, logic [31:0] center, int span);
        logic [31:0] v;
        case (mode)
            0: v = $urandom;
            1: begin
                case ($urandom_range(0, 4))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'hFFFF_FFFF;
                    3: v = 32'h0000_0000;
                    default: v = 32'h0000_0001;
                endcase
            end
            4: v = center + $urandom_range(0, 2) * span;
            default: v = center + $urandom_range(0, span) - span / 2;
        endcase
        return v;
    endfunction

    task automatic add_random_set(int n, bit drain);
        int          mode;
        logic [31:0] center;
        int          span;
        mode = $urandom_range(0, 5);
        center = $urandom;
        case ($urandom_range(0, 4))
            0: span = 0;
            1: span = 3;
            2: span = 40;
            3: span = 5000;
            default: span = 1 << 20;
        endcase
        for (int k = 0; k < n; k++)
            add_sample(draw_value(mode, center, span), k == n - 1, drain && k == 0);
        sets_queued++;
    endtask

    // driver: bursts of words separated by random gaps
    bit           presenting;
    sample_word_t cur_word;
    int           burst_left = 1;
    int           gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            presenting = s_valid;
            if (s_valid && s_ready) begin
                absorb_sample(cur_word);
                presenting = 1'b0;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            if (!presenting) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending.size() > 0
                        && (!pending[0].after_drain || bins_due.size() == 0)) begin
                    cur_word = pending.pop_front();
                    s_sample <= cur_word.sample;
                    s_last <= cur_word.last;
                    presenting = 1'b1;
                end
            end
            s_valid <= presenting;
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // monitor: receiver stalls on a changing duty cycle, with two long hold-offs
    int        ready_pct = 100;
    int        pattern_left = 0;
    int        holdoff_left = 0;
    bin_word_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (bins_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected bin word, index %0d low %0h count %0d",
                             $time, m_bin_index, m_bin_low, m_bin_count);
                end else begin
                    want = bins_due.pop_front();
                    check_field("bin_index", want.index, m_bin_index);
                    check_field("bin_low", want.low, m_bin_low);
                    check_field("bin_count", want.count, m_bin_count);
                    check_field("dropped", want.dropped, m_dropped);
                    check_field("final_bin", want.final_bin, m_final_bin);
                end
                bins_checked++;
                if (bins_checked == 70 || bins_checked == 400)
                    holdoff_left = 600;
            end
            if (pattern_left == 0) begin
                pattern_left = $urandom_range(16, 96);
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 75;
                    2: ready_pct = 40;
                    default: ready_pct = 10;
                endcase
            end else begin
                pattern_left--;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(1, 100) <= ready_pct);
            end
        end
    end

    initial begin
        int n;

        // single samples at both extremes
        add_sample(32'h7FFF_FFFF, 1'b1, 1'b0);
        add_sample(32'h8000_0000, 1'b1, 1'b0);
        // full range
        add_sample(32'h8000_0000, 1'b0, 1'b0);
        add_sample(32'h7FFF_FFFF, 1'b1, 1'b0);
        // samples sitting on bin edges
        add_sample(32'd0, 1'b0, 1'b1);
        add_sample(32'd4096, 1'b0, 1'b0);
        add_sample(32'd40960, 1'b0, 1'b0);
        add_sample(32'd81919, 1'b0, 1'b0);
        add_sample(32'd81920, 1'b1, 1'b0);
        // single value repeated
        add_sample(32'd5, 1'b0, 1'b0);
        add_sample(32'd5, 1'b0, 1'b0);
        add_sample(32'd5, 1'b1, 1'b0);
        add_sample(-32'sd1000000, 1'b0, 1'b0);
        add_sample(32'sd1000000, 1'b0, 1'b0);
        add_sample(32'd0, 1'b0, 1'b0);
        add_sample(32'd12345, 1'b1, 1'b0);
        // range narrower than the zone count truncates to zero width
        add_sample(32'd3, 1'b0, 1'b0);
        add_sample(32'd10, 1'b1, 1'b0);
        sets_queued = 7;

        while (random_items < 200) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            add_random_set(n, (sets_queued % 6) == 0);
            random_items += n;
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending.size() != 0 || s_valid || bins_due.size() != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);

        $display("Loaded %0d samples in %0d sets; checked %0d bin words.",
                 samples_taken, sets_closed, bins_checked);
        $display("Covered extreme, edge-aligned, single-value and random sets under stalls.");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
